[src/dda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  localparam int COORD_BITS = 6;
  localparam int FRAC_BITS  = 16;

  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int QUOT_W     = FRAC_BITS + 1;
  localparam int INC_W      = FRAC_BITS + 2;
  localparam int ACC_W      = COORD_BITS + 1 + FRAC_BITS;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_first;
    logic apply;
    logic emit;
  } dda_cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic cnt_zero;
    logic out_free;
  } dda_status_t;

endpackage

`default_nettype wire

[src/dda_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module dda_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  dda_pkg::dda_status_t status_i,
  output dda_pkg::dda_cmd_t    cmd_o
);

  import dda_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_e;

  localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(DIV_STEPS - 1);

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          div_cnt_d  = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.steps_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_step  = 1'b1;
          cmd_o.div_first = (div_cnt_q == '0);
          div_cnt_d       = div_cnt_q + 1'b1;
          if (div_cnt_q == DivLast) begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.cnt_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

`default_nettype wire

[src/dda_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module dda_datapath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  dda_pkg::dda_cmd_t    cmd_i,
  output dda_pkg::dda_status_t status_o,
  input  dda_pkg::coord_t      start_x_i,
  input  dda_pkg::coord_t      start_y_i,
  input  dda_pkg::coord_t      end_x_i,
  input  dda_pkg::coord_t      end_y_i,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  output dda_pkg::coord_t      pixel_x_o,
  output dda_pkg::coord_t      pixel_y_o,
  output logic                 last_point_o
);

  import dda_pkg::*;

  localparam logic [ACC_W-1:0] Half = ACC_W'(1) << (FRAC_BITS - 1);

  logic signed [DIFF_W-1:0] dx, dy;
  logic [COORD_BITS-1:0]    mag_x, mag_y, steps;

  logic [COORD_BITS-1:0]    steps_q, cnt_q;
  logic [COORD_BITS-1:0]    rem_x_q, rem_y_q;
  logic [QUOT_W-1:0]        quot_x_q, quot_y_q;
  logic                     neg_x_q, neg_y_q;
  logic signed [INC_W-1:0]  inc_x_q, inc_y_q;
  logic signed [ACC_W-1:0]  acc_x_q, acc_y_q;
  logic                     out_valid_q;
  coord_t                   pixel_x_q, pixel_y_q;
  logic                     last_q;

  logic [COORD_BITS:0]      trial_x, trial_y, div_x, div_y;
  logic                     ge_x, ge_y;
  logic [ACC_W-1:0]         rnd_x, rnd_y;

  assign dx    = DIFF_W'(end_x_i) - DIFF_W'(start_x_i);
  assign dy    = DIFF_W'(end_y_i) - DIFF_W'(start_y_i);
  assign mag_x = dx[DIFF_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign mag_y = dy[DIFF_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
  assign steps = (mag_x > mag_y) ? mag_x : mag_y;

  assign div_x   = {1'b0, steps_q};
  assign div_y   = {1'b0, steps_q};
  assign trial_x = cmd_i.div_first ? {1'b0, rem_x_q} : {rem_x_q, 1'b0};
  assign trial_y = cmd_i.div_first ? {1'b0, rem_y_q} : {rem_y_q, 1'b0};
  assign ge_x    = (trial_x >= div_x);
  assign ge_y    = (trial_y >= div_y);

  assign rnd_x = acc_x_q + Half - ACC_W'(acc_x_q[ACC_W-1]);
  assign rnd_y = acc_y_q + Half - ACC_W'(acc_y_q[ACC_W-1]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      steps_q <= steps;
      rem_x_q <= mag_x;
      rem_y_q <= mag_y;
      neg_x_q <= dx[DIFF_W-1];
      neg_y_q <= dy[DIFF_W-1];
      acc_x_q <= {start_x_i[COORD_BITS-1], start_x_i, {FRAC_BITS{1'b0}}};
      acc_y_q <= {start_y_i[COORD_BITS-1], start_y_i, {FRAC_BITS{1'b0}}};
    end else if (cmd_i.emit && !status_o.cnt_zero) begin
      acc_x_q <= acc_x_q + {{(ACC_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
      acc_y_q <= acc_y_q + {{(ACC_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
    end
    if (cmd_i.div_step) begin
      rem_x_q  <= ge_x ? COORD_BITS'(trial_x - div_x) : COORD_BITS'(trial_x);
      rem_y_q  <= ge_y ? COORD_BITS'(trial_y - div_y) : COORD_BITS'(trial_y);
      quot_x_q <= {quot_x_q[QUOT_W-2:0], ge_x};
      quot_y_q <= {quot_y_q[QUOT_W-2:0], ge_y};
    end
    if (cmd_i.apply) begin
      inc_x_q <= neg_x_q ? -INC_W'(quot_x_q) : INC_W'(quot_x_q);
      inc_y_q <= neg_y_q ? -INC_W'(quot_y_q) : INC_W'(quot_y_q);
    end
    if (cmd_i.emit) begin
      pixel_x_q <= rnd_x[FRAC_BITS +: COORD_BITS];
      pixel_y_q <= rnd_y[FRAC_BITS +: COORD_BITS];
      last_q    <= status_o.cnt_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= steps;
      end else if (cmd_i.emit && !status_o.cnt_zero) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.cnt_zero   = (cnt_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign last_point_o = last_q;

endmodule

`default_nettype wire

[src/dda_line_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Line rasterizer: each request carries two endpoints and produces steps+1 points,
// steps being the larger of |dx| and |dy|, with tlast on the final point. A line
// is taken in, then the per-step increments are computed (a bit-serial divider
// yields one quotient bit a cycle for x and y together), the increments are
// signed, then one point per cycle comes from the accumulator pair while the
// output side is ready; a zero-length line skips the divider and the signing. A
// new request is taken as soon as the last point of the previous line is in the
// output register.

module dda_line_rasterizer (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire  [dda_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // pixel_x, pixel_y, zero pad
  output logic [dda_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);

  import dda_pkg::*;

  dda_cmd_t    cmd;
  dda_status_t status;
  coord_t      start_x, start_y, end_x, end_y;
  coord_t      pixel_x, pixel_y;

  assign start_x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
  assign start_y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
  assign end_x   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign end_y   = s_axis_tdata[3*COORD_BITS +: COORD_BITS];

  dda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dda_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_x_i    (start_x),
    .start_y_i    (start_y),
    .end_x_i      (end_x),
    .end_y_i      (end_y),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .last_point_o (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'({pixel_y, pixel_x});

endmodule

`default_nettype wire

[src/dda_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module dda_chk (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [dda_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire                            m_axis_tlast
);

  logic s_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output request changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input taken again before the line was drawn");

  a_idle_holds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("ready for a new line while points of the previous one remain");

endmodule

bind dda_line_rasterizer dda_chk u_dda_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  import dda_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } point_t;

  class line_scoreboard;
    point_t expected_points[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    static function longint round_half_away(longint v);
      longint half;
      half = longint'(1) <<< (FRAC_BITS - 1);
      if (v >= 0) return (v + half) >>> FRAC_BITS;
      return -((-v + half) >>> FRAC_BITS);
    endfunction

    static function longint step_increment(longint d, longint steps);
      longint q;
      q = ((d < 0 ? -d : d) <<< FRAC_BITS) / steps;
      return d < 0 ? -q : q;
    endfunction

    // Expand one accepted line request into its rasterized points.
    function void note_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      longint dx, dy, adx, ady, steps, x_inc, y_inc, x_acc, y_acc, rx, ry;
      point_t p;
      dx    = longint'(ex) - longint'(sx);
      dy    = longint'(ey) - longint'(sy);
      adx   = dx < 0 ? -dx : dx;
      ady   = dy < 0 ? -dy : dy;
      steps = adx > ady ? adx : ady;
      x_inc = 0;
      y_inc = 0;
      if (steps > 0) begin
        x_inc = step_increment(dx, steps);
        y_inc = step_increment(dy, steps);
      end
      x_acc = longint'(sx) <<< FRAC_BITS;
      y_acc = longint'(sy) <<< FRAC_BITS;
      for (longint k = 0; k <= steps; k++) begin
        rx     = round_half_away(x_acc);
        ry     = round_half_away(y_acc);
        p.x    = rx[COORD_BITS-1:0];
        p.y    = ry[COORD_BITS-1:0];
        p.last = (k == steps);
        expected_points.insert(expected_points.size(), p);
        x_acc += x_inc;
        y_acc += y_inc;
      end
    endfunction

    function void check_point(coord_t px, coord_t py, logic last);
      point_t e;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time, px, py, last);
        errors++;
        return;
      end
      e = expected_points.pop_front();
      if (px !== e.x) begin
        $display("%0t: pixel_x expected %0d got %0d", $time, e.x, px);
        errors++;
      end
      if (py !== e.y) begin
        $display("%0t: pixel_y expected %0d got %0d", $time, e.y, py);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_point expected %0b got %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int             sender_idle_pct    = 0;
  int             receiver_stall_pct = 0;
  line_scoreboard sb;

  dda_line_rasterizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_point(m_axis_tdata[COORD_BITS-1:0],
                     m_axis_tdata[2*COORD_BITS-1:COORD_BITS], m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[4*COORD_BITS-1:0] = {ey, ex, sy, sx};
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_DATA_W'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_line(sx, sy, ex, ey);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_line();
    coord_t sx, sy, ex, ey;
    int     kind;
    sx   = coord_t'($urandom);
    sy   = coord_t'($urandom);
    ex   = coord_t'($urandom);
    ey   = coord_t'($urandom);
    kind = $urandom_range(9);
    // short lines, axis-aligned lines, degenerate points
    if (kind < 3) begin
      ex = sx + coord_t'($urandom_range(8)) - coord_t'(4);
      ey = sy + coord_t'($urandom_range(8)) - coord_t'(4);
    end else if (kind == 3) begin
      ey = sy;
    end else if (kind == 4) begin
      ex = sx;
    end else if (kind == 5) begin
      ex = sx;
      ey = sy;
    end
    send_line(sx, sy, ex, ey);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_line(-32, -32, -32, -32);
    send_line(31, 31, 31, 31);
    send_line(0, 0, 0, 0);
    send_line(-32, -32, 31, 31);
    send_line(31, 31, -32, -32);
    send_line(-32, 0, 31, 0);
    send_line(0, 31, 0, -32);
    send_line(31, -32, -32, 31);
    send_line(-32, 31, 31, -32);
    send_line(0, 0, 2, 1);
    send_line(0, 0, -2, -1);
    send_line(1, 1, -1, 0);
    send_line(0, 0, 3, 1);
    send_line(0, 0, -3, -2);
    send_line(0, 0, 7, -3);
    send_line(-32, 5, 31, -7);
    send_line(5, -3, -6, 20);
    send_line(-21, 10, 21, -11);
    send_line(3, -4, 4, -3);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
      endcase
      repeat (25) send_random_line();
      drain();
    end

    receiver_stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
